/* rtl/core/fbpa_pkg.sv */
// shared types and constants for the fixed block pool allocator
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int ADDR_WIDTH_DEF = 32;

    localparam int SIZE_W    = 16;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd8;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_OFFSET,
        S_DIV,
        S_MUL,
        S_FINISH
    } t_state;

endpackage

/* rtl/core/fbpa_req_if.sv */
// request channel: operation and address
interface fbpa_req_if #(
    parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [ADDR_WIDTH-1:0] address;

    modport source (output valid, output op, output address, input ready);
    modport sink   (input valid, input op, input address, output ready);
endinterface

/* rtl/core/fbpa_rsp_if.sv */
// response channel: block address and status
interface fbpa_rsp_if #(
    parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] block_address;
    logic [1:0]            status;

    modport source (output valid, output block_address, output status, input ready);
    modport sink   (input valid, input block_address, input status, output ready);
endinterface

/* rtl/core/fixed_block_pool_allocator_unit.sv */
// fixed block pool allocator top level with index-linked free stack
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    op, address
//  o_rsp     out  valid/ready    block_address, status
//  i_cfg     in   i_cfg_we       i_cfg_index, i_cfg_data
//
// free: subtracts the base, then divides by the block size on the shared add/sub unit, one quotient bit a cycle
// allocate: base plus stack top times block size (shift-add multiply on the same unit), skipped when empty
// after reset and after every write to a known config register the link memory is rebuilt entry by entry,
// during which i_req.ready is low
// a finished transaction waits in the output register; a full register stalls the last step
module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_WIDTH-1:0]          i_cfg_data,
    fbpa_req_if.sink                       i_req,
    fbpa_rsp_if.source                     o_rsp
);

    localparam int SW     = fbpa_pkg::SIZE_W;
    localparam int IW     = $clog2(MAX_BLOCKS);
    localparam int CW0    = $clog2(MAX_BLOCKS + 1);
    localparam int CW     = (CW0 > fbpa_pkg::COUNT_W) ? CW0 : fbpa_pkg::COUNT_W;
    localparam int CMPW   = (ADDR_WIDTH > CW) ? ADDR_WIDTH : CW;
    localparam int STEP_W = $clog2(ADDR_WIDTH);
    localparam int UW     = ADDR_WIDTH + 1;

    localparam logic [CW-1:0]     MAX_CNT    = CW'(MAX_BLOCKS);
    localparam logic [IW-1:0]     LAST_SWEEP = IW'(MAX_BLOCKS - 1);
    localparam logic [STEP_W-1:0] LAST_DIV   = STEP_W'(ADDR_WIDTH - 1);
    localparam logic [STEP_W-1:0] LAST_MUL   = STEP_W'(IW - 1);

    fbpa_pkg::t_state  r_state, n_state;
    logic [ADDR_WIDTH-1:0] r_base, n_base;
    logic [SW-1:0]         r_size, n_size;
    logic [fbpa_pkg::COUNT_W-1:0] r_count, n_count;
    logic [IW-1:0]         r_top, n_top;
    logic                  r_top_valid, n_top_valid;
    logic                  r_op, n_op;
    logic [ADDR_WIDTH-1:0] r_acc, n_acc;
    logic [SW-1:0]         r_rem, n_rem;
    logic [ADDR_WIDTH-1:0] r_addend, n_addend;
    logic [IW-1:0]         r_mbits, n_mbits;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [IW-1:0]         r_sweep, n_sweep;
    logic                  r_out_valid, n_out_valid;
    logic [ADDR_WIDTH-1:0] r_out_addr, n_out_addr;
    fbpa_pkg::t_status     r_out_status, n_out_status;

    logic [IW:0] r_link_mem [MAX_BLOCKS];
    logic [IW:0] r_rd;
    logic        m_we;
    logic [IW-1:0] m_waddr;
    logic [IW:0]   m_wdata;

    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] eff_cnt;
    logic [SW-1:0] eff_size;
    logic [CW-1:0] sweep_next;
    logic          accept;
    logic          in_range;

    // shared add/sub unit
    logic [UW-1:0] u_a, u_b, u_sum;
    logic          u_sub;
    logic [SW:0]   div_shift;
    logic          div_ge;

    assign cnt_ext    = CW'(r_count);
    assign eff_cnt    = (cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext;
    assign eff_size   = (r_size == '0) ? SW'(1) : r_size;
    assign sweep_next = CW'(r_sweep) + CW'(1);
    assign in_range   = CMPW'(r_acc) < CMPW'(eff_cnt);

    assign div_shift = {r_rem, r_acc[ADDR_WIDTH-1]};
    assign div_ge    = ~u_sum[UW-1];

    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        case (r_state)
            fbpa_pkg::S_OFFSET: begin
                u_a   = {1'b0, r_acc};
                u_b   = {1'b0, r_base};
                u_sub = 1'b1;
            end
            fbpa_pkg::S_DIV: begin
                u_a   = UW'(div_shift);
                u_b   = UW'(eff_size);
                u_sub = 1'b1;
            end
            fbpa_pkg::S_MUL: begin
                u_a = {1'b0, r_acc};
                u_b = {1'b0, r_addend};
            end
            default: begin
            end
        endcase
    end

    assign u_sum = u_a + (u_sub ? ~u_b : u_b) + UW'(u_sub);

    assign i_req.ready = (r_state == fbpa_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_size       = r_size;
        n_count      = r_count;
        n_top        = r_top;
        n_top_valid  = r_top_valid;
        n_op         = r_op;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_addend     = r_addend;
        n_mbits      = r_mbits;
        n_step       = r_step;
        n_sweep      = r_sweep;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        m_we         = 1'b0;
        m_waddr      = r_sweep;
        m_wdata      = '0;

        unique case (r_state)
            fbpa_pkg::S_SWEEP: begin
                m_we    = 1'b1;
                m_waddr = r_sweep;
                m_wdata = {(sweep_next < eff_cnt), sweep_next[IW-1:0]};
                n_sweep = r_sweep + IW'(1);
                if (r_sweep == LAST_SWEEP) begin
                    n_state     = fbpa_pkg::S_IDLE;
                    n_sweep     = '0;
                    n_top       = '0;
                    n_top_valid = (eff_cnt != '0);
                end
            end
            fbpa_pkg::S_IDLE: begin
                if (accept) begin
                    n_op = i_req.op;
                    if (i_req.op == fbpa_pkg::OP_ALLOC) begin
                        if (r_top_valid) begin
                            n_acc    = r_base;
                            n_addend = ADDR_WIDTH'(eff_size);
                            n_mbits  = r_top;
                            n_step   = LAST_MUL;
                            n_state  = fbpa_pkg::S_MUL;
                        end else begin
                            n_state = fbpa_pkg::S_FINISH;
                        end
                    end else begin
                        n_acc   = i_req.address;
                        n_state = fbpa_pkg::S_OFFSET;
                    end
                end
            end
            fbpa_pkg::S_OFFSET: begin
                n_acc   = u_sum[ADDR_WIDTH-1:0];
                n_rem   = '0;
                n_step  = LAST_DIV;
                n_state = fbpa_pkg::S_DIV;
            end
            fbpa_pkg::S_DIV: begin
                n_rem  = div_ge ? u_sum[SW-1:0] : div_shift[SW-1:0];
                n_acc  = {r_acc[ADDR_WIDTH-2:0], div_ge};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = fbpa_pkg::S_FINISH;
                end
            end
            fbpa_pkg::S_MUL: begin
                if (r_mbits[0]) begin
                    n_acc = u_sum[ADDR_WIDTH-1:0];
                end
                n_mbits  = r_mbits >> 1;
                n_addend = r_addend << 1;
                n_step   = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = fbpa_pkg::S_FINISH;
                end
            end
            fbpa_pkg::S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = '0;
                    n_state     = fbpa_pkg::S_IDLE;
                    if (r_op == fbpa_pkg::OP_FREE) begin
                        if (in_range) begin
                            m_we         = 1'b1;
                            m_waddr      = r_acc[IW-1:0];
                            m_wdata      = {r_top_valid, r_top};
                            n_top        = r_acc[IW-1:0];
                            n_top_valid  = 1'b1;
                            n_out_status = fbpa_pkg::ST_OK;
                        end else begin
                            n_out_status = fbpa_pkg::ST_INVALID;
                        end
                    end else if (r_top_valid) begin
                        n_top        = r_rd[IW-1:0];
                        n_top_valid  = r_rd[IW];
                        n_out_addr   = r_acc;
                        n_out_status = fbpa_pkg::ST_OK;
                    end else begin
                        n_out_status = fbpa_pkg::ST_EMPTY;
                    end
                end
            end
            default: begin
                n_state = fbpa_pkg::S_SWEEP;
                n_sweep = '0;
            end
        endcase

        // any known register write rebuilds the free list
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fbpa_pkg::CFG_BASE_ADDRESS: begin
                    n_base  = i_cfg_data;
                    n_state = fbpa_pkg::S_SWEEP;
                    n_sweep = '0;
                end
                fbpa_pkg::CFG_BLOCK_SIZE: begin
                    n_size  = i_cfg_data[SW-1:0];
                    n_state = fbpa_pkg::S_SWEEP;
                    n_sweep = '0;
                end
                fbpa_pkg::CFG_BLOCK_COUNT: begin
                    n_count = i_cfg_data[fbpa_pkg::COUNT_W-1:0];
                    n_state = fbpa_pkg::S_SWEEP;
                    n_sweep = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbpa_pkg::S_SWEEP;
            r_base      <= '0;
            r_size      <= fbpa_pkg::SIZE_RESET;
            r_count     <= fbpa_pkg::COUNT_RESET;
            r_top       <= '0;
            r_top_valid <= 1'b0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_size      <= n_size;
            r_count     <= n_count;
            r_top       <= n_top;
            r_top_valid <= n_top_valid;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_addend     <= n_addend;
        r_mbits      <= n_mbits;
        r_step       <= n_step;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_link_mem[m_waddr] <= m_wdata;
        end
        r_rd <= r_link_mem[r_top];
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.block_address = r_out_addr;
    assign o_rsp.status        = r_out_status;

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != fbpa_pkg::ST_OK)) |-> (r_out_addr == '0))
        else $error("failed transaction carries a nonzero address");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while a transaction is in progress");

    a_top_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != fbpa_pkg::S_SWEEP) && r_top_valid) |-> (CW'(r_top) < eff_cnt))
        else $error("free stack top outside the pool");

    a_finish_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == fbpa_pkg::S_FINISH) && !r_out_valid && !i_cfg_we) |=> r_out_valid)
        else $error("finished transaction did not reach the output register");

endmodule
